### src/tcc_pkg.sv
package tcc_pkg;

    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = CHAR_W + ATTR_W;

    localparam logic [1:0] MODE_PUT  = 2'd0;
    localparam logic [1:0] MODE_SET  = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;
    localparam logic [CELL_W-1:0] RESET_CELL   = {RESET_ATTR, BLANK_CHAR};

    // controller to datapath
    typedef struct packed {
        logic item_load;   // latch the accepted request
        logic exec;        // apply the request to cursor and store
        logic sweep_zero;  // restart the cell sweep counter
        logic sweep_step;  // handle one cell of a sweep and advance
        logic sweep_init;  // sweep fills with the reset cell
        logic out_load;    // load the result register
    } tcc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_scroll;
        logic sweep_last;
    } tcc_status_t;

endpackage

### src/text_console_cursor_scroll.sv
// Channel  Direction  Handshake           Payload
// input    in         in_valid/in_stall   mode, char_code, column_in, row_in
// output   out        out_valid/out_stall cursor_column, cursor_row, cell_data, scrolled
// config   in         cfg_we              cfg_data (text color attribute)
//
// A request passes through accept, execute on the cell store, and load of the result register.
// A put that scrolls adds one sweep of the store (one write port, one read port),
// one cell copied or blanked per cycle.
// After reset a clearing pass writes every cell; input stalls meanwhile.
// A new request is accepted while the previous result waits under out_stall.
module text_console_cursor_scroll
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [7:0]  char_code,
    input  logic [6:0]  column_in,
    input  logic [4:0]  row_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  cursor_column,
    output logic [4:0]  cursor_row,
    output logic [15:0] cell_data,
    output logic        scrolled
);
    import tcc_pkg::*;

    tcc_cmd_t    cmd;
    tcc_status_t status;

    tcc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tcc_dp
    #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .mode          (mode),
        .char_code     (char_code),
        .column_in     (column_in),
        .row_in        (row_in),
        .cursor_column (cursor_column),
        .cursor_row    (cursor_row),
        .cell_data     (cell_data),
        .scrolled      (scrolled)
    );

endmodule

### src/tcc_ctrl.sv
module tcc_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  tcc_pkg::tcc_status_t status,
    output tcc_pkg::tcc_cmd_t    cmd
);
    import tcc_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.sweep_step = 1'b1;
                cmd.sweep_init = 1'b1;
                if (status.sweep_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.item_load = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec       = 1'b1;
                cmd.sweep_zero = 1'b1;
                state_next     = status.need_scroll ? ST_SCROLL : ST_DONE;
            end
            ST_SCROLL:
            begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold the result until the output slot frees up
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### src/tcc_dp.sv
module tcc_dp
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcc_pkg::tcc_cmd_t    cmd,
    output tcc_pkg::tcc_status_t status,
    input  logic                 cfg_we,
    input  logic [7:0]           cfg_data,
    input  logic [1:0]           mode,
    input  logic [7:0]           char_code,
    input  logic [6:0]           column_in,
    input  logic [4:0]           row_in,
    output logic [6:0]           cursor_column,
    output logic [4:0]           cursor_row,
    output logic [15:0]          cell_data,
    output logic                 scrolled
);
    import tcc_pkg::*;

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    logic [CELL_W-1:0] mem [CELL_COUNT];
    logic [CELL_W-1:0] rdata_reg;

    logic [ATTR_W-1:0] color_reg;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;

    logic [1:0]        it_mode_reg;
    logic [CHAR_W-1:0] it_char_reg;
    logic [COL_W-1:0]  it_col_reg, it_col_clamp;
    logic [ROW_W-1:0]  it_row_reg, it_row_clamp;

    logic              scroll_flag_reg;

    logic [ADDR_W-1:0] sweep_idx_reg;
    logic              sw_blank;
    logic              sw_read;
    logic              wr_en_reg;
    logic [ADDR_W-1:0] wr_addr_reg;
    logic              wr_from_mem_reg;
    logic [CELL_W-1:0] wr_data_reg;

    logic              exec_put;
    logic              exec_read;
    logic              at_last_col;
    logic              at_last_row;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] it_addr;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic [31:0]       col_ext;
    logic [31:0]       row_ext;

    // clamp on capture
    always_comb
    begin
        if (32'(column_in) > COLUMNS - 1)
            it_col_clamp = COL_W'(COLUMNS - 1);
        else
            it_col_clamp = COL_W'(column_in);
        if (32'(row_in) > ROWS - 1)
            it_row_clamp = ROW_W'(ROWS - 1);
        else
            it_row_clamp = ROW_W'(row_in);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            it_mode_reg <= mode;
            it_char_reg <= char_code;
            it_col_reg  <= it_col_clamp;
            it_row_reg  <= it_row_clamp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            color_reg <= RESET_ATTR;
        else if (cfg_we)
            color_reg <= cfg_data;
    end

    assign at_last_col = (cur_col_reg == COL_W'(COLUMNS - 1));
    assign at_last_row = (cur_row_reg == ROW_W'(ROWS - 1));
    assign exec_put    = cmd.exec && (it_mode_reg == MODE_PUT) && (it_char_reg != NEWLINE_CODE);
    assign exec_read   = cmd.exec && (it_mode_reg == MODE_READ);
    assign cur_addr    = ADDR_W'(cur_row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col_reg);
    assign it_addr     = ADDR_W'(it_row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(it_col_reg);

    assign status.need_scroll = (it_mode_reg == MODE_PUT) && at_last_row &&
                                ((it_char_reg == NEWLINE_CODE) || at_last_col);
    assign status.sweep_last  = (sweep_idx_reg == ADDR_W'(CELL_COUNT - 1));

    // cursor update
    always_comb
    begin
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        if (cmd.exec)
        begin
            case (it_mode_reg)
                MODE_PUT:
                begin
                    if ((it_char_reg == NEWLINE_CODE) || at_last_col)
                    begin
                        cur_col_next = '0;
                        if (!at_last_row)
                            cur_row_next = cur_row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        cur_col_next = cur_col_reg + COL_W'(1);
                    end
                end
                MODE_SET:
                begin
                    cur_col_next = it_col_reg;
                    cur_row_next = it_row_reg;
                end
                default:
                begin
                    cur_col_next = cur_col_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg     <= '0;
            cur_row_reg     <= '0;
            scroll_flag_reg <= 1'b0;
        end
        else
        begin
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            if (cmd.exec)
                scroll_flag_reg <= status.need_scroll;
        end
    end

    // sweep: a copy reads cell i+COLUMNS, then writes cell i in the following cycle
    assign sw_blank = (sweep_idx_reg >= ADDR_W'(CELL_COUNT - COLUMNS));
    assign sw_read  = cmd.sweep_step && !cmd.sweep_init && !sw_blank;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_idx_reg <= '0;
            wr_en_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.sweep_zero)
                sweep_idx_reg <= '0;
            else if (cmd.sweep_step)
                sweep_idx_reg <= sweep_idx_reg + ADDR_W'(1);
            wr_en_reg <= cmd.sweep_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sweep_step)
        begin
            wr_addr_reg     <= sweep_idx_reg;
            wr_from_mem_reg <= sw_read;
            wr_data_reg     <= cmd.sweep_init ? RESET_CELL : {color_reg, BLANK_CHAR};
        end
    end

    // single write port, single registered read port
    always_comb
    begin
        mem_we = wr_en_reg || exec_put;
        if (wr_en_reg)
        begin
            mem_waddr = wr_addr_reg;
            mem_wdata = wr_from_mem_reg ? rdata_reg : wr_data_reg;
        end
        else
        begin
            mem_waddr = cur_addr;
            mem_wdata = {color_reg, it_char_reg};
        end
        mem_re    = sw_read || exec_read;
        mem_raddr = sw_read ? (sweep_idx_reg + ADDR_W'(COLUMNS)) : it_addr;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

    assign col_ext = 32'(cur_col_reg);
    assign row_ext = 32'(cur_row_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            cursor_column <= col_ext[6:0];
            cursor_row    <= row_ext[4:0];
            cell_data     <= (it_mode_reg == MODE_READ) ? rdata_reg : '0;
            scrolled      <= scroll_flag_reg;
        end
    end

endmodule
